@@ rtl/core/cvg_pkg.sv @@
package cvg_pkg;

    localparam int unsigned COORD_W  = 24;
    localparam int unsigned DIFF_W   = 25;
    localparam int unsigned TRIG_W   = 16;
    localparam int unsigned RANGE_W  = 48;
    localparam int unsigned SLOPE_W  = 18;
    localparam int unsigned COLOR_W  = 2;
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 48;

    localparam int unsigned PROD_W  = DIFF_W + TRIG_W;
    localparam int unsigned ROT_W   = PROD_W + 1;
    localparam int unsigned DIST_W  = 2 * COORD_W + 1;
    localparam int unsigned FRAC_SH = 14;
    localparam int unsigned SPLIT_W = 21;

    localparam logic signed [COORD_W-1:0] COORD_MAX = 24'sh7FFFFF;
    localparam logic signed [COORD_W-1:0] COORD_MIN = 24'sh800000;

    localparam logic [COORD_W-1:0] VEHICLE_X_RST   = 24'd0;
    localparam logic [COORD_W-1:0] VEHICLE_Y_RST   = 24'd0;
    localparam logic [TRIG_W-1:0]  HEADING_COS_RST = 16'd16384;
    localparam logic [TRIG_W-1:0]  HEADING_SIN_RST = 16'd0;
    localparam logic [RANGE_W-1:0] RANGE_SQ_RST    = 48'd40960000;
    localparam logic [SLOPE_W-1:0] VIEW_SLOPE_RST  = 18'd28378;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_VEHICLE_X   = 3'd0,
        CFG_VEHICLE_Y   = 3'd1,
        CFG_HEADING_COS = 3'd2,
        CFG_HEADING_SIN = 3'd3,
        CFG_RANGE_SQ    = 3'd4,
        CFG_VIEW_SLOPE  = 3'd5
    } cfg_index_t;

endpackage

@@ rtl/core/cone_view_gate_and_frame_rotate.sv @@
// Five register stages lie between an accepted input beat and its output beat.
// Throughput: one beat per cycle; the slope multiply is split over two stages.
// Output stalls pause this, holding full stages; in_stall follows when full.
// Reset clears the stage valid bits and loads the default configuration:
// vehicle at origin heading +x, range 25 m, half view angle 60 degrees.
module cone_view_gate_and_frame_rotate (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_wr_en,
    input  logic [cvg_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [cvg_pkg::CFG_DATA_W-1:0]        cfg_data,
    input  logic                                  in_valid,
    output logic                                  in_stall,
    input  logic signed [cvg_pkg::COORD_W-1:0]    marker_x,
    input  logic signed [cvg_pkg::COORD_W-1:0]    marker_y,
    input  logic [cvg_pkg::COLOR_W-1:0]           marker_color,
    output logic                                  out_valid,
    input  logic                                  out_stall,
    output logic                                  in_view,
    output logic signed [cvg_pkg::COORD_W-1:0]    rel_x,
    output logic signed [cvg_pkg::COORD_W-1:0]    rel_y,
    output logic [cvg_pkg::COLOR_W-1:0]           out_color,
    output logic                                  clipped
);

    localparam int unsigned CW  = cvg_pkg::COORD_W;
    localparam int unsigned DW  = cvg_pkg::DIFF_W;
    localparam int unsigned TW  = cvg_pkg::TRIG_W;
    localparam int unsigned PW  = cvg_pkg::PROD_W;
    localparam int unsigned RW  = cvg_pkg::ROT_W;
    localparam int unsigned SW  = cvg_pkg::SLOPE_W;
    localparam int unsigned LW  = cvg_pkg::SPLIT_W;
    localparam int unsigned HW  = PW - LW;
    localparam int unsigned FS  = cvg_pkg::FRAC_SH;
    localparam int unsigned SHW = RW + 1 - FS;

    // configuration registers
    logic signed [CW-1:0]             vehicle_x_reg;
    logic signed [CW-1:0]             vehicle_y_reg;
    logic signed [TW-1:0]             heading_cos_reg;
    logic signed [TW-1:0]             heading_sin_reg;
    logic [cvg_pkg::RANGE_W-1:0]      range_sq_reg;
    logic [SW-1:0]                    view_slope_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vehicle_x_reg   <= cvg_pkg::VEHICLE_X_RST;
            vehicle_y_reg   <= cvg_pkg::VEHICLE_Y_RST;
            heading_cos_reg <= cvg_pkg::HEADING_COS_RST;
            heading_sin_reg <= cvg_pkg::HEADING_SIN_RST;
            range_sq_reg    <= cvg_pkg::RANGE_SQ_RST;
            view_slope_reg  <= cvg_pkg::VIEW_SLOPE_RST;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                cvg_pkg::CFG_VEHICLE_X:   vehicle_x_reg   <= cfg_data[CW-1:0];
                cvg_pkg::CFG_VEHICLE_Y:   vehicle_y_reg   <= cfg_data[CW-1:0];
                cvg_pkg::CFG_HEADING_COS: heading_cos_reg <= cfg_data[TW-1:0];
                cvg_pkg::CFG_HEADING_SIN: heading_sin_reg <= cfg_data[TW-1:0];
                cvg_pkg::CFG_RANGE_SQ:    range_sq_reg    <= cfg_data[cvg_pkg::RANGE_W-1:0];
                cvg_pkg::CFG_VIEW_SLOPE:  view_slope_reg  <= cfg_data[SW-1:0];
                default: ;
            endcase
        end
    end

    // stage valid bits and hold chain
    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg;
    logic rdy1, rdy2, rdy3, rdy4, rdy5;

    assign rdy5 = !v5_reg || !out_stall;
    assign rdy4 = !v4_reg || rdy5;
    assign rdy3 = !v3_reg || rdy4;
    assign rdy2 = !v2_reg || rdy3;
    assign rdy1 = !v1_reg || rdy2;
    assign in_stall = !rdy1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end
        else
        begin
            if (rdy1) v1_reg <= in_valid;
            if (rdy2) v2_reg <= v1_reg;
            if (rdy3) v3_reg <= v2_reg;
            if (rdy4) v4_reg <= v3_reg;
            if (rdy5) v5_reg <= v4_reg;
        end
    end

    // stage 1: offset from vehicle
    logic signed [DW-1:0]           dx_reg, dy_reg, dx_next, dy_next;
    logic [cvg_pkg::COLOR_W-1:0]    col1_reg, col2_reg, col3_reg, col4_reg, col5_reg;

    assign dx_next = {marker_x[CW-1], marker_x} - {vehicle_x_reg[CW-1], vehicle_x_reg};
    assign dy_next = {marker_y[CW-1], marker_y} - {vehicle_y_reg[CW-1], vehicle_y_reg};

    always_ff @(posedge clk)
    begin
        if (rdy1)
        begin
            dx_reg   <= dx_next;
            dy_reg   <= dy_next;
            col1_reg <= marker_color;
        end
    end

    // stage 2: rotation products and squares
    logic signed [PW-1:0] pxc_reg, pys_reg, pyc_reg, pxs_reg;
    logic [2*CW-1:0]      sqx_reg, sqy_reg;
    logic [DW-1:0]        ax_full, ay_full;
    logic [CW-1:0]        ax, ay;
    logic                 zero2_reg;

    assign ax_full = dx_reg[DW-1] ? -dx_reg : dx_reg;
    assign ay_full = dy_reg[DW-1] ? -dy_reg : dy_reg;
    assign ax      = ax_full[CW-1:0];
    assign ay      = ay_full[CW-1:0];

    always_ff @(posedge clk)
    begin
        if (rdy2)
        begin
            pxc_reg   <= dx_reg * heading_cos_reg;
            pys_reg   <= dy_reg * heading_sin_reg;
            pyc_reg   <= dy_reg * heading_cos_reg;
            pxs_reg   <= dx_reg * heading_sin_reg;
            sqx_reg   <= ax * ax;
            sqy_reg   <= ay * ay;
            zero2_reg <= (dx_reg == '0) && (dy_reg == '0);
            col2_reg  <= col1_reg;
        end
    end

    // stage 3: sums and range test
    logic signed [RW-1:0]         rx_reg, ry_reg, rx_next, ry_next;
    logic [cvg_pkg::DIST_W-1:0]   dist2;
    logic                         range_ok3_reg, zero3_reg;

    assign rx_next = {pxc_reg[PW-1], pxc_reg} + {pys_reg[PW-1], pys_reg};
    assign ry_next = {pyc_reg[PW-1], pyc_reg} - {pxs_reg[PW-1], pxs_reg};
    assign dist2   = {1'b0, sqx_reg} + {1'b0, sqy_reg};

    always_ff @(posedge clk)
    begin
        if (rdy3)
        begin
            rx_reg        <= rx_next;
            ry_reg        <= ry_next;
            range_ok3_reg <= dist2 < {1'b0, range_sq_reg};
            zero3_reg     <= zero2_reg;
            col3_reg      <= col2_reg;
        end
    end

    // stage 4: cone operands, split slope multiply, round and saturate
    logic signed [RW-1:0]   cone_a, cone_b;
    logic [RW-1:0]          bmag, bmag4_reg;
    logic [SW+LW-1:0]       plo4_reg;
    logic [SW+HW-1:0]       phi4_reg;
    logic                   apos4_reg, range_ok4_reg;
    logic signed [RW:0]     rx_bias, ry_bias;
    logic signed [SHW-1:0]  rx_sh, ry_sh;
    logic signed [CW-1:0]   rx_sat, ry_sat;
    logic                   rx_clip, ry_clip;
    logic signed [CW-1:0]   relx4_reg, rely4_reg;
    logic                   clip4_reg;

    assign cone_a = zero3_reg ? RW'(heading_cos_reg) : rx_reg;
    assign cone_b = zero3_reg ? RW'(heading_sin_reg) : ry_reg;
    assign bmag   = cone_b[RW-1] ? -cone_b : cone_b;

    assign rx_bias = {rx_reg[RW-1], rx_reg} + (RW+1)'(1 << (FS - 1));
    assign ry_bias = {ry_reg[RW-1], ry_reg} + (RW+1)'(1 << (FS - 1));
    assign rx_sh   = rx_bias[RW:FS];
    assign ry_sh   = ry_bias[RW:FS];

    always_comb
    begin
        rx_clip = 1'b1;
        ry_clip = 1'b1;
        if (rx_sh > SHW'(cvg_pkg::COORD_MAX))
            rx_sat = cvg_pkg::COORD_MAX;
        else if (rx_sh < SHW'(cvg_pkg::COORD_MIN))
            rx_sat = cvg_pkg::COORD_MIN;
        else
        begin
            rx_sat  = rx_sh[CW-1:0];
            rx_clip = 1'b0;
        end
        if (ry_sh > SHW'(cvg_pkg::COORD_MAX))
            ry_sat = cvg_pkg::COORD_MAX;
        else if (ry_sh < SHW'(cvg_pkg::COORD_MIN))
            ry_sat = cvg_pkg::COORD_MIN;
        else
        begin
            ry_sat  = ry_sh[CW-1:0];
            ry_clip = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy4)
        begin
            plo4_reg      <= view_slope_reg * cone_a[LW-1:0];
            phi4_reg      <= view_slope_reg * cone_a[PW-1:LW];
            bmag4_reg     <= bmag;
            apos4_reg     <= !cone_a[RW-1] && (cone_a != '0);
            range_ok4_reg <= range_ok3_reg;
            relx4_reg     <= rx_sat;
            rely4_reg     <= ry_sat;
            clip4_reg     <= rx_clip || ry_clip;
            col4_reg      <= col3_reg;
        end
    end

    // stage 5: cone compare, output register
    logic [SW+PW:0]     slope_prod;
    logic [RW+FS-1:0]   lhs;
    logic               view5_reg, clip5_reg;
    logic signed [CW-1:0] relx5_reg, rely5_reg;

    assign slope_prod = {1'b0, phi4_reg, LW'(0)} + (SW+PW+1)'(plo4_reg);
    assign lhs        = {bmag4_reg, FS'(0)};

    always_ff @(posedge clk)
    begin
        if (rdy5)
        begin
            view5_reg <= range_ok4_reg && apos4_reg && ((SW+PW+1)'(lhs) < slope_prod);
            relx5_reg <= relx4_reg;
            rely5_reg <= rely4_reg;
            clip5_reg <= clip4_reg;
            col5_reg  <= col4_reg;
        end
    end

    assign out_valid = v5_reg;
    assign in_view   = view5_reg;
    assign rel_x     = relx5_reg;
    assign rel_y     = rely5_reg;
    assign clipped   = clip5_reg;
    assign out_color = col5_reg;

    a_view_ahead: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && in_view) |-> !rel_x[CW-1])
        else $error("visible marker with negative forward offset");

    a_no_hold_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        !out_stall |-> !in_stall)
        else $error("input held while output drains");

    a_clip_at_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && clipped) |->
            (rel_x == cvg_pkg::COORD_MAX || rel_x == cvg_pkg::COORD_MIN ||
             rel_y == cvg_pkg::COORD_MAX || rel_y == cvg_pkg::COORD_MIN))
        else $error("clip flag without saturated offset");

endmodule
